// ===== hdl/perceptron_train_classify_unit_defines.svh =====
// Assertion macros shared by the perceptron unit checker.
`ifndef PERCEPTRON_TRAIN_CLASSIFY_UNIT_DEFINES_SVH
`define PERCEPTRON_TRAIN_CLASSIFY_UNIT_DEFINES_SVH

// Antecedent and consequent in the same cycle, ignored while in reset.
`define PTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("perceptron unit: same-cycle property violated");

// Consequent in the cycle after the antecedent, ignored while in reset.
`define PTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("perceptron unit: next-cycle property violated");

// Consequent in the cycle after reset has been sampled high.
`define PTC_ASSERT_AFTER_RESET(label, clk, rst, cons) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error("perceptron unit: post-reset property violated");

`endif

// ===== hdl/ptc_pkg.sv =====
// Types, constants and helper functions of the perceptron unit.
`default_nettype none

package ptc_pkg;

   localparam int NUM_FEATURES  = 4;
   localparam int FEATURE_SLOTS = 4;
   localparam int NUM_WEIGHTS   = NUM_FEATURES + 1;

   localparam int ACTION_W  = 2;
   localparam int FEATURE_W = 8;
   localparam int INDEX_W   = 3;
   localparam int WEIGHT_W  = 32;
   localparam int SCORE_W   = 48;
   localparam int RATE_W    = 16;
   localparam int PRODUCT_W = WEIGHT_W + FEATURE_W;
   localparam int STEP_W    = RATE_W + 2;
   localparam int DELTA_W   = STEP_W + FEATURE_W;

   localparam logic [ACTION_W-1:0] ACTION_CLASSIFY = 2'd0;
   localparam logic [ACTION_W-1:0] ACTION_TRAIN    = 2'd1;
   localparam logic [ACTION_W-1:0] ACTION_WRITE    = 2'd2;

   localparam logic [RATE_W-1:0] LEARNING_RATE_RESET = 16'd655;

   typedef logic signed [WEIGHT_W-1:0] weight_type;

   typedef struct packed {
      logic [ACTION_W-1:0]                       action;
      logic [FEATURE_SLOTS-1:0][FEATURE_W-1:0]   feature;
      logic                                      label_positive;
      logic [INDEX_W-1:0]                        weight_index;
      logic [WEIGHT_W-1:0]                       weight_value;
   } ptc_req_type;

   typedef struct packed {
      logic                      class_positive;
      logic                      mistake;
      logic signed [SCORE_W-1:0] score;
   } ptc_rsp_type;

   typedef struct packed {
      logic [NUM_WEIGHTS-1:0]               load;
      logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] value;
   } ptc_weight_upd_type;

   // Clamp a one-bit-wider sum back into the signed weight range.
   function automatic weight_type sat_weight(input logic signed [WEIGHT_W:0] sum);
      weight_type result;
      if (sum[WEIGHT_W] != sum[WEIGHT_W-1]) begin
         result = sum[WEIGHT_W] ? {1'b1, {(WEIGHT_W-1){1'b0}}} : {1'b0, {(WEIGHT_W-1){1'b1}}};
      end else begin
         result = sum[WEIGHT_W-1:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/ptc_if.sv =====
// Valid/ready channel interfaces for the request and response beats.
`default_nettype none

interface ptc_req_if;
   logic                                     valid;
   logic                                     ready;
   logic [ptc_pkg::ACTION_W-1:0]             action;
   logic signed [ptc_pkg::FEATURE_W-1:0]     feature_0;
   logic signed [ptc_pkg::FEATURE_W-1:0]     feature_1;
   logic signed [ptc_pkg::FEATURE_W-1:0]     feature_2;
   logic signed [ptc_pkg::FEATURE_W-1:0]     feature_3;
   logic                                     label_positive;
   logic [ptc_pkg::INDEX_W-1:0]              weight_index;
   logic signed [ptc_pkg::WEIGHT_W-1:0]      weight_value;

   modport source (output valid, action, feature_0, feature_1, feature_2, feature_3,
                   label_positive, weight_index, weight_value, input ready);
   modport sink   (input valid, action, feature_0, feature_1, feature_2, feature_3,
                   label_positive, weight_index, weight_value, output ready);
endinterface

interface ptc_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 class_positive;
   logic                                 mistake;
   logic signed [ptc_pkg::SCORE_W-1:0]   score;

   modport source (output valid, class_positive, mistake, score, input ready);
   modport sink   (input valid, class_positive, mistake, score, output ready);
endinterface

`default_nettype wire

// ===== hdl/perceptron_train_classify_unit.sv =====
// Top level of the perceptron classify and train unit.
// This unit holds a bias and four signed Q16.16 feature weights and takes one
// request beat per clock cycle: classify, train on a sample, or load a weight.
// A request is first captured in an input register; in the following cycle the
// four 32x8 products, the score adder tree, the sign decision and the saturating
// weight update all settle in one combinational stage, and the response beat
// and the new weights are registered together at the same edge. The response
// beat is therefore registered behind the input register, and with a ready sink
// the sustained rate is one beat per cycle, set by that single compute stage.
// Because weights are committed at the same edge as the response, the next
// request always sees the effect of the one before it. The response register
// lets a new request enter while a finished response waits for the sink; the
// request side stalls only when both registers are full and the sink is not
// ready. The learning rate is written through the csr port and must only be
// changed while no beat is in flight.
`default_nettype none

module perceptron_train_classify_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [ptc_pkg::RATE_W-1:0]    csr_write_data,
   ptc_req_if.sink                       req_chan,
   ptc_rsp_if.source                     rsp_chan
);

   // Input register stage.
   logic                         req_valid_ff;
   logic                         req_valid_in;
   ptc_pkg::ptc_req_type         req_ff;
   ptc_pkg::ptc_req_type         req_in;

   // Response register stage.
   logic                         rsp_valid_ff;
   logic                         rsp_valid_in;
   ptc_pkg::ptc_rsp_type         rsp_ff;
   ptc_pkg::ptc_rsp_type         rsp_in;

   // Learning rate register.
   logic [ptc_pkg::RATE_W-1:0]   rate_ff;
   logic [ptc_pkg::RATE_W-1:0]   rate_in;

   ptc_pkg::weight_type          weights [ptc_pkg::NUM_WEIGHTS];
   ptc_pkg::ptc_weight_upd_type  upd;
   logic                         advance;
   logic                         req_take;

   // The compute stage moves a held request forward whenever the response slot is free or
   // is being emptied in this very cycle.
   assign advance        = req_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !req_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      req_in.action         = req_chan.action;
      req_in.feature[0]     = req_chan.feature_0;
      req_in.feature[1]     = req_chan.feature_1;
      req_in.feature[2]     = req_chan.feature_2;
      req_in.feature[3]     = req_chan.feature_3;
      req_in.label_positive = req_chan.label_positive;
      req_in.weight_index   = req_chan.weight_index;
      req_in.weight_value   = req_chan.weight_value;

      req_valid_in = req_chan.ready ? req_chan.valid : req_valid_ff;

      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end

      rate_in = csr_write_enable ? csr_write_data : rate_ff;
   end

   ptc_datapath u_datapath (
      .req           (req_ff),
      .weights       (weights),
      .learning_rate (rate_ff),
      .rsp           (rsp_in),
      .upd           (upd)
   );

   ptc_weight_bank u_weight_bank (
      .clock   (clock),
      .reset   (reset),
      .commit  (advance),
      .upd     (upd),
      .weights (weights)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rate_ff      <= ptc_pkg::LEARNING_RATE_RESET;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         rate_ff      <= rate_in;
      end
   end

   // Payload registers load only on a moving beat and need no reset.
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.class_positive = rsp_ff.class_positive;
   assign rsp_chan.mistake        = rsp_ff.mistake;
   assign rsp_chan.score          = rsp_ff.score;

endmodule

`default_nettype wire

// ===== hdl/ptc_datapath.sv =====
// Score, prediction and weight update logic for one registered request.
`default_nettype none

module ptc_datapath (
   input  ptc_pkg::ptc_req_type         req,
   input  ptc_pkg::weight_type          weights [ptc_pkg::NUM_WEIGHTS],
   input  logic [ptc_pkg::RATE_W-1:0]   learning_rate,
   output ptc_pkg::ptc_rsp_type         rsp,
   output ptc_pkg::ptc_weight_upd_type  upd
);

   logic signed [ptc_pkg::FEATURE_W-1:0] feat   [ptc_pkg::NUM_FEATURES];
   logic signed [ptc_pkg::PRODUCT_W-1:0] prod   [ptc_pkg::NUM_FEATURES];
   logic signed [ptc_pkg::DELTA_W-1:0]   delta  [ptc_pkg::NUM_FEATURES];
   logic signed [ptc_pkg::WEIGHT_W:0]    wsum   [ptc_pkg::NUM_FEATURES];
   logic signed [ptc_pkg::SCORE_W-1:0]   score;
   logic signed [ptc_pkg::STEP_W-1:0]    step_mag;
   logic signed [ptc_pkg::STEP_W-1:0]    step;
   logic signed [ptc_pkg::WEIGHT_W:0]    bias_sum;
   logic                                 pos;
   logic                                 miss;

   always_comb begin
      score = ptc_pkg::SCORE_W'(weights[0]);
      for (int i = 0; i < ptc_pkg::NUM_FEATURES; i++) begin
         feat[i]  = $signed(req.feature[i]);
         prod[i]  = weights[i + 1] * feat[i];
         score    = score + ptc_pkg::SCORE_W'(prod[i]);
      end
      pos = ~score[ptc_pkg::SCORE_W-1];

      // Rate in Q0.16 times two, signed by the label direction.
      step_mag = $signed({1'b0, learning_rate, 1'b0});
      step     = req.label_positive ? step_mag : -step_mag;
      bias_sum = (ptc_pkg::WEIGHT_W + 1)'(weights[0]) + (ptc_pkg::WEIGHT_W + 1)'(step);
      for (int i = 0; i < ptc_pkg::NUM_FEATURES; i++) begin
         delta[i] = step * feat[i];
         wsum[i]  = (ptc_pkg::WEIGHT_W + 1)'(weights[i + 1])
                  + (ptc_pkg::WEIGHT_W + 1)'(delta[i]);
      end
   end

   always_comb begin
      miss = 1'b0;
      upd  = '0;
      rsp.class_positive = pos;
      rsp.mistake        = 1'b0;
      rsp.score          = score;
      unique case (req.action)
         ptc_pkg::ACTION_TRAIN: begin
            miss        = (req.label_positive != pos);
            rsp.mistake = miss;
            upd.load    = {ptc_pkg::NUM_WEIGHTS{miss}};
            upd.value[0] = ptc_pkg::sat_weight(bias_sum);
            for (int j = 1; j < ptc_pkg::NUM_WEIGHTS; j++) begin
               upd.value[j] = ptc_pkg::sat_weight(wsum[j - 1]);
            end
         end
         ptc_pkg::ACTION_WRITE: begin
            rsp = '0;
            for (int j = 0; j < ptc_pkg::NUM_WEIGHTS; j++) begin
               upd.load[j]  = (req.weight_index == ptc_pkg::INDEX_W'(j));
               upd.value[j] = req.weight_value;
            end
         end
         default: begin
            // Classify, and the undefined action code treated the same way.
            miss = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== hdl/ptc_weight_bank.sv =====
// Bias and feature weight registers, cleared to zero at reset.
`default_nettype none

module ptc_weight_bank (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         commit,
   input  ptc_pkg::ptc_weight_upd_type  upd,
   output ptc_pkg::weight_type          weights [ptc_pkg::NUM_WEIGHTS]
);

   ptc_pkg::weight_type weight_ff [ptc_pkg::NUM_WEIGHTS];
   ptc_pkg::weight_type weight_in [ptc_pkg::NUM_WEIGHTS];

   always_comb begin
      for (int j = 0; j < ptc_pkg::NUM_WEIGHTS; j++) begin
         weight_in[j] = (commit && upd.load[j]) ? $signed(upd.value[j]) : weight_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < ptc_pkg::NUM_WEIGHTS; j++) begin
            weight_ff[j] <= '0;
         end
      end else begin
         weight_ff <= weight_in;
      end
   end

   assign weights = weight_ff;

endmodule

`default_nettype wire

// ===== hdl/ptc_checker.sv =====
// Port-level checker for the perceptron unit, bound to the top level.
`default_nettype none
`include "perceptron_train_classify_unit_defines.svh"

module ptc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic                               rsp_class_positive,
   input logic                               rsp_mistake,
   input logic signed [ptc_pkg::SCORE_W-1:0] rsp_score
);

   logic [ptc_pkg::SCORE_W+1:0] rsp_payload;
   logic                        rsp_stall;
   logic                        score_negative;
   logic                        negative_miss;

   assign rsp_payload    = {rsp_class_positive, rsp_mistake, rsp_score};
   assign rsp_stall      = rsp_valid && !rsp_ready;
   assign score_negative = rsp_score[ptc_pkg::SCORE_W-1];
   assign negative_miss  = rsp_valid && rsp_mistake && !rsp_class_positive;

   `PTC_ASSERT_AFTER_RESET(a_rsp_idle_after_reset, clock, reset, !rsp_valid)

   `PTC_ASSERT_NEXT(a_rsp_held_on_stall, clock, reset, rsp_stall, rsp_valid && $stable(rsp_payload))

   `PTC_ASSERT_SAME(a_req_stall_only_when_full, clock, reset, !req_ready, rsp_stall)

   `PTC_ASSERT_SAME(a_class_matches_sign, clock, reset, rsp_valid && rsp_class_positive, !score_negative)

   `PTC_ASSERT_SAME(a_negative_miss_sign, clock, reset, negative_miss, score_negative)

endmodule

bind perceptron_train_classify_unit ptc_checker u_ptc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_class_positive (rsp_chan.class_positive),
   .rsp_mistake        (rsp_chan.mistake),
   .rsp_score          (rsp_chan.score)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench of the perceptron classify and train unit.
module tb_top;
   import ptc_pkg::*;

   // Action code that the unit has no meaning for; it must behave as classify.
   localparam logic [ACTION_W-1:0] ACTION_UNDEFINED = 2'd3;
   localparam int BIAS_INDEX = 0;

   // Saturation bounds of a Q16.16 weight, held wide so that sums never wrap.
   localparam longint WEIGHT_MAX = (longint'(1) <<< (WEIGHT_W - 1)) - 1;
   localparam longint WEIGHT_MIN = -(longint'(1) <<< (WEIGHT_W - 1));

   // Raw bit patterns of the largest and smallest weight, for loads.
   localparam logic [WEIGHT_W-1:0] WEIGHT_TOP    = 32'h7FFF_FFFF;
   localparam logic [WEIGHT_W-1:0] WEIGHT_BOTTOM = 32'h8000_0000;

   localparam int PHASES          = 8;
   localparam int BEATS_PER_PHASE = 130;

   // Mirror of the weights and the learning rate. Every accepted request beat
   // is played through it in order, and the response it should produce is
   // queued; every response beat is then compared with the oldest entry.
   class perceptron_mirror;
      weight_type        weight [NUM_WEIGHTS];
      logic [RATE_W-1:0] rate;
      ptc_rsp_type       due_rsp [$];
      int                mismatches;

      function new();
         foreach (weight[i]) weight[i] = '0;
         rate       = LEARNING_RATE_RESET;
         mismatches = 0;
      endfunction

      static function weight_type clamp_weight(longint sum);
         weight_type result;
         if (sum > WEIGHT_MAX) begin
            result = WEIGHT_TOP;
         end else if (sum < WEIGHT_MIN) begin
            result = WEIGHT_BOTTOM;
         end else begin
            result = sum[WEIGHT_W-1:0];
         end
         return result;
      endfunction

      function void take_request(ptc_req_type beat);
         ptc_rsp_type rsp;
         longint      feat [FEATURE_SLOTS];
         longint      acc;
         longint      step;
         logic        positive;
         int          i;
         rsp = '0;
         if (beat.action == ACTION_WRITE) begin
            // A load to an index past the last weight is dropped silently.
            if (beat.weight_index <= NUM_FEATURES) begin
               weight[beat.weight_index] = beat.weight_value;
            end
         end else begin
            acc = longint'(weight[BIAS_INDEX]);
            for (i = 0; i < NUM_FEATURES; i++) begin
               feat[i] = longint'($signed(beat.feature[i]));
               acc += longint'(weight[i+1]) * feat[i];
            end
            positive = (acc >= 0);
            // One prediction serves the whole update; the step is the rate
            // times (label - prediction), i.e. twice the rate, signed.
            if (beat.action == ACTION_TRAIN && beat.label_positive != positive) begin
               step = 2 * longint'(rate);
               if (!beat.label_positive) begin
                  step = -step;
               end
               weight[BIAS_INDEX] = clamp_weight(longint'(weight[BIAS_INDEX]) + step);
               for (i = 0; i < NUM_FEATURES; i++) begin
                  weight[i+1] = clamp_weight(longint'(weight[i+1]) + step * feat[i]);
               end
               rsp.mistake = 1'b1;
            end
            rsp.class_positive = positive;
            rsp.score          = acc[SCORE_W-1:0];
         end
         due_rsp.push_back(rsp);
      endfunction

      function void check_response(ptc_rsp_type got);
         ptc_rsp_type want;
         if (due_rsp.size() == 0) begin
            $display("%0t: response beat with nothing outstanding: class %0b mistake %0b score %0d",
                     $time, got.class_positive, got.mistake, got.score);
            mismatches++;
            return;
         end
         want = due_rsp.pop_front();
         if (got.class_positive !== want.class_positive) begin
            $display("%0t: class_positive expected %0b actual %0b",
                     $time, want.class_positive, got.class_positive);
            mismatches++;
         end
         if (got.mistake !== want.mistake) begin
            $display("%0t: mistake expected %0b actual %0b", $time, want.mistake, got.mistake);
            mismatches++;
         end
         if (got.score !== want.score) begin
            $display("%0t: score expected %0d actual %0d", $time, want.score, got.score);
            mismatches++;
         end
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              csr_write_enable;
   logic [RATE_W-1:0] csr_write_data;

   ptc_req_if req_chan ();
   ptc_rsp_if rsp_chan ();

   perceptron_mirror mirror;

   // Percentages of cycles in which the sender holds back a beat and the
   // receiver refuses one; the main sequence changes them phase by phase.
   int req_idle_pct;
   int rsp_stall_pct;

   // Hidden separating plane used to label most training samples, so that
   // training runs as it would on real data and the weights settle.
   int target_w [NUM_WEIGHTS];

   perceptron_train_classify_unit dut (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop in case the handshake locks up.
   initial begin
      #(12 * 200000);
      $display("FAILURE");
      $finish;
   end

   // The receiver decides afresh at every edge whether it will take a beat.
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Both channels are sampled at the edge, before any of the nonblocking
   // updates of that edge land. The response is checked before the request is
   // noted, although a response can never belong to a beat taken at the same
   // edge, as the beat must first pass the input and the response registers.
   always @(posedge clock) begin : watch
      ptc_rsp_type got;
      ptc_req_type seen;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.class_positive = rsp_chan.class_positive;
            got.mistake        = rsp_chan.mistake;
            got.score          = rsp_chan.score;
            mirror.check_response(got);
         end
         if (req_chan.valid && req_chan.ready) begin
            seen.action         = req_chan.action;
            seen.feature[0]     = req_chan.feature_0;
            seen.feature[1]     = req_chan.feature_1;
            seen.feature[2]     = req_chan.feature_2;
            seen.feature[3]     = req_chan.feature_3;
            seen.label_positive = req_chan.label_positive;
            seen.weight_index   = req_chan.weight_index;
            seen.weight_value   = req_chan.weight_value;
            mirror.take_request(seen);
         end
      end
   end

   // Features lean towards the extremes and the values either side of zero.
   function automatic logic [FEATURE_W-1:0] pick_feature();
      logic [FEATURE_W-1:0] f;
      f = FEATURE_W'($urandom_range(255));
      if ($urandom_range(99) < 15) begin
         case ($urandom_range(4))
            0:       f = 8'h80;
            1:       f = 8'h7F;
            2:       f = 8'h00;
            3:       f = 8'hFF;
            default: f = 8'h01;
         endcase
      end
      return f;
   endfunction

   // Loaded weights: the saturation bounds, zero, small values that training
   // can still move about, and fully random patterns.
   function automatic logic [WEIGHT_W-1:0] pick_weight_value();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         return WEIGHT_TOP;
      end else if (r < 20) begin
         return WEIGHT_BOTTOM;
      end else if (r < 30) begin
         return '0;
      end else if (r < 60) begin
         return int'($urandom_range(2 ** 21 - 1)) - 2 ** 20;
      end
      return $urandom;
   endfunction

   // Every field starts fully random, so that fields an action ignores carry
   // junk; then the action is chosen. The largest share, 45 percent of beats, are
   // training samples labelled by the hidden plane; the rest are noisy labels,
   // classifications, loads (some to indexes past the last weight) and the undefined action.
   function automatic ptc_req_type make_beat();
      ptc_req_type it;
      int          r;
      int          dot;
      int          i;
      it.action         = ACTION_W'($urandom_range(3));
      it.label_positive = 1'($urandom_range(1));
      it.weight_index   = INDEX_W'($urandom_range(7));
      it.weight_value   = $urandom;
      for (i = 0; i < FEATURE_SLOTS; i++) begin
         it.feature[i] = pick_feature();
      end
      r = $urandom_range(99);
      if (r < 45) begin
         it.action = ACTION_TRAIN;
         dot = target_w[BIAS_INDEX];
         for (i = 0; i < NUM_FEATURES; i++) begin
            dot += target_w[i+1] * int'($signed(it.feature[i]));
         end
         it.label_positive = (dot >= 0);
      end else if (r < 55) begin
         it.action = ACTION_TRAIN;
      end else if (r < 78) begin
         it.action = ACTION_CLASSIFY;
      end else if (r < 90) begin
         it.action       = ACTION_WRITE;
         it.weight_index = ($urandom_range(99) < 85)
                         ? INDEX_W'($urandom_range(NUM_FEATURES))
                         : INDEX_W'($urandom_range(7, NUM_WEIGHTS));
         it.weight_value = pick_weight_value();
      end else if (r < 95) begin
         it.action = ACTION_UNDEFINED;
      end
      return it;
   endfunction

   // Offers one beat, after a random number of idle cycles, and returns at the
   // edge where it is taken. Valid is left high so back-to-back beats need no
   // second assignment in the same step.
   task automatic send_beat(input ptc_req_type it);
      while ($urandom_range(99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.action         <= it.action;
      req_chan.feature_0      <= it.feature[0];
      req_chan.feature_1      <= it.feature[1];
      req_chan.feature_2      <= it.feature[2];
      req_chan.feature_3      <= it.feature[3];
      req_chan.label_positive <= it.label_positive;
      req_chan.weight_index   <= it.weight_index;
      req_chan.weight_value   <= it.weight_value;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   task automatic send_fields(input logic [ACTION_W-1:0] action,
                              input logic [FEATURE_W-1:0] f0, input logic [FEATURE_W-1:0] f1,
                              input logic [FEATURE_W-1:0] f2, input logic [FEATURE_W-1:0] f3,
                              input logic label, input logic [INDEX_W-1:0] index,
                              input logic [WEIGHT_W-1:0] value);
      ptc_req_type it;
      it.action         = action;
      it.feature[0]     = f0;
      it.feature[1]     = f1;
      it.feature[2]     = f2;
      it.feature[3]     = f3;
      it.label_positive = label;
      it.weight_index   = index;
      it.weight_value   = value;
      send_beat(it);
   endtask

   // Holds the sender back until every response has come, then waits on for anything
   // still inside the two-stage pipeline. The first edge lets the watcher note the
   // beat taken at the edge we returned from.
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (mirror.due_rsp.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   // Only called with the unit idle; the rate is taken at the edge.
   task automatic write_rate(input logic [RATE_W-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      mirror.rate = value;
   endtask

   initial begin : main
      logic [RATE_W-1:0] rate_plan [PHASES];
      int                phase;
      int                n;
      int                i;

      mirror = new();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;

      reset                   <= 1'b1;
      csr_write_enable        <= 1'b0;
      csr_write_data          <= '0;
      req_chan.valid          <= 1'b0;
      req_chan.action         <= ACTION_CLASSIFY;
      req_chan.feature_0      <= '0;
      req_chan.feature_1      <= '0;
      req_chan.feature_2      <= '0;
      req_chan.feature_3      <= '0;
      req_chan.label_positive <= 1'b0;
      req_chan.weight_index   <= '0;
      req_chan.weight_value   <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset rate written back explicitly.
      write_rate(LEARNING_RATE_RESET);
      // Zero weights give a zero score, which must count as the positive class.
      send_fields(ACTION_CLASSIFY, 0, 0, 0, 0, 1'b0, 0, '0);
      // Extreme features with junk in every field that classify ignores.
      send_fields(ACTION_CLASSIFY, -128, 127, -128, 127, 1'b1, 7, $urandom);
      // Zero score against a negative label: a mistake with extreme features.
      send_fields(ACTION_TRAIN, 127, -128, 1, -1, 1'b0, 3, $urandom);
      send_fields(ACTION_TRAIN, -128, 127, -128, 127, 1'b1, 0, '0);
      send_fields(ACTION_TRAIN, 1, 1, 1, 1, 1'b1, 0, '0);
      // The undefined action must classify and never flag a mistake.
      send_fields(ACTION_UNDEFINED, 127, 127, 127, 127, 1'b0, 2, $urandom);
      // Loads past the last weight change nothing.
      send_fields(ACTION_WRITE, 5, 5, 5, 5, 1'b1, 5, WEIGHT_TOP);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 6, WEIGHT_BOTTOM);
      send_fields(ACTION_WRITE, -1, -1, -1, -1, 1'b1, 7, $urandom);
      // Bias at the top and the first weight one above the bottom: the score
      // is exactly zero, the label negative, so the first weight saturates low.
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 0, WEIGHT_TOP);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 1, WEIGHT_BOTTOM + 1);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 2, '0);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 3, '0);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 4, '0);
      send_fields(ACTION_TRAIN, 1, 0, 0, 0, 1'b0, 0, '0);
      // Score of minus one against a positive label: the first weight
      // saturates high.
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 0, WEIGHT_BOTTOM);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 1, WEIGHT_TOP);
      send_fields(ACTION_TRAIN, 1, 0, 0, 0, 1'b1, 0, '0);
      // A deeply negative score with the bias at the top: the bias saturates.
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 0, WEIGHT_TOP);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 1, WEIGHT_BOTTOM);
      send_fields(ACTION_TRAIN, 2, 0, 0, 0, 1'b1, 0, '0);
      // Weights at alternating bounds give large products of opposite sign.
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 2, WEIGHT_TOP);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 3, WEIGHT_BOTTOM);
      send_fields(ACTION_WRITE, 0, 0, 0, 0, 1'b0, 4, WEIGHT_TOP);
      send_fields(ACTION_CLASSIFY, -128, -128, -128, -128, 1'b1, 1, $urandom);
      drain();

      // Random part. The rate runs through both extremes, the smallest step
      // and a few arbitrary values, while the idling pattern cycles through
      // none, sender idle, receiver stalling and a light mix of both.
      rate_plan = '{16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd32768, 16'd0};
      rate_plan[2] = RATE_W'($urandom_range(2, 65534));
      rate_plan[5] = RATE_W'($urandom_range(2, 65534));
      rate_plan[7] = RATE_W'($urandom_range(2, 65534));
      for (phase = 0; phase < PHASES; phase++) begin
         case (phase % 4)
            0: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 0;
            end
            1: begin
               req_idle_pct  = 64;
               rsp_stall_pct = 0;
            end
            2: begin
               req_idle_pct  = 0;
               rsp_stall_pct = 64;
            end
            default: begin
               req_idle_pct  = 7;
               rsp_stall_pct = 7;
            end
         endcase
         for (i = 0; i < NUM_WEIGHTS; i++) begin
            target_w[i] = int'($urandom_range(16)) - 8;
         end
         write_rate(rate_plan[phase]);
         for (n = 0; n < BEATS_PER_PHASE; n++) begin
            // Mid-phase, and now and then at random, the sender waits for the
            // pipeline to empty completely before going on.
            if (n == BEATS_PER_PHASE / 2 || $urandom_range(199) == 0) begin
               drain();
            end
            send_beat(make_beat());
         end
         drain();
      end

      repeat (10) @(posedge clock);
      if (mirror.mismatches == 0 && mirror.due_rsp.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
